// ----- design/assert_macros.svh -----
// Assertion helpers shared by the line buffer RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

// ----- design/ppplb_pkg.sv -----
`default_nettype none

package ppplb_pkg;

  localparam int WORD_W      = 64;
  localparam int PIXEL_W     = 12;
  localparam int ADDR_W      = 32;
  localparam int CFG_INDEX_W = 2;

  // Input mode codes
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_BEAT  = 2'd1;
  localparam logic [1:0] MODE_GRANT = 2'd2;

  // Read response code for a good beat
  localparam logic [1:0] RESP_OKAY = 2'd0;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP  = 2'd1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [WORD_W-1:0] beat_data;
    logic [1:0]        beat_response;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [ADDR_W-1:0]  fetch_address;
    logic               fetch_enable;
    logic               display_bank;
    logic               swapped;
  } result_t;

  // Operation decoded by the front end
  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_BEAT,
    OP_GRANT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              store;
    logic [WORD_W-1:0] data;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [ADDR_W-1:0]      data;
  } cfg_write_t;

endpackage

`default_nettype wire

// ----- design/ppplb_ram.sv -----
`default_nettype none

module ppplb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/ppplb_front.sv -----
`default_nettype none

`include "assert_macros.svh"

module ppplb_front
  import ppplb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  input  wire logic     pop,
  output queue_head_t   head
);

  logic [1:0]   count;
  queue_entry_t slot0;
  queue_entry_t slot1;
  queue_entry_t entry_in;
  logic         push;

  // Classify the incoming item
  always_comb begin
    entry_in.data  = in_item.beat_data;
    entry_in.store = (in_item.beat_response == RESP_OKAY);
    unique case (in_item.mode)
      MODE_PIXEL: entry_in.op = OP_PIXEL;
      MODE_BEAT:  entry_in.op = OP_BEAT;
      MODE_GRANT: entry_in.op = OP_GRANT;
      default:    entry_in.op = OP_NONE;
    endcase
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head.valid = (count != 2'd0);
  assign head.entry = slot0;

  // Two-entry queue, head always in slot0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (pop) begin
      slot0 <= (push && count == 2'd1) ? entry_in : slot1;
      if (push && count == 2'd2) begin
        slot1 <= entry_in;
      end else if (push) begin
        slot1 <= entry_in;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= entry_in;
      end else begin
        slot1 <= entry_in;
      end
    end
  end

  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && count == 2'd0, "pop from empty queue")

endmodule

`default_nettype wire

// ----- design/ppplb_back.sv -----
`default_nettype none

`include "assert_macros.svh"

module ppplb_back
  import ppplb_pkg::*;
#(
  parameter int WORDS_PER_BANK = 32,
  parameter int FETCH_STRIDE   = 256,
  parameter int PIXEL_BITS     = 12,
  parameter int LANES_PER_WORD = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire queue_head_t head,
  output logic             pop,
  input  wire cfg_write_t  cfg,
  output logic             result_valid,
  output result_t          result
);

  localparam int WBITS      = $clog2(WORDS_PER_BANK);
  localparam int LBITS      = (LANES_PER_WORD > 1) ? $clog2(LANES_PER_WORD) : 1;
  localparam int ABITS      = WBITS + 1;
  localparam int DEPTH      = 2 ** ABITS;
  localparam int LANE_WIDTH = WORD_W / LANES_PER_WORD;
  localparam logic [WBITS-1:0]   WORD_LAST = WBITS'(WORDS_PER_BANK - 1);
  localparam logic [LBITS-1:0]   LANE_LAST = LBITS'(LANES_PER_WORD - 1);
  localparam logic [PIXEL_W-1:0] PIX_MASK  = PIXEL_W'((1 << PIXEL_BITS) - 1);
  localparam logic [ADDR_W:0]    STRIDE    = (ADDR_W + 1)'(FETCH_STRIDE);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t             state, state_next;
  logic [WBITS-1:0]   read_word_index, read_word_index_next;
  logic [LBITS-1:0]   lane_index, lane_index_next;
  logic [WBITS-1:0]   fill_word_index, fill_word_index_next;
  logic               fill_done, fill_done_next;
  logic               display_select, display_select_next;
  logic [ADDR_W-1:0]  base_address, base_address_next;
  logic [ADDR_W-1:0]  top_address, top_address_next;
  logic [ADDR_W-1:0]  next_fetch_address, next_fetch_address_next;
  logic [ADDR_W-1:0]  fetch_hold, fetch_hold_next;
  logic [PIXEL_W-1:0] pixel_hold, pixel_hold_next;
  logic               swapped_next;
  logic               emit;
  logic [DEPTH-1:0]   word_valid;
  logic               rd_valid;

  logic [ABITS-1:0]   raddr;
  logic [ABITS-1:0]   waddr;
  logic               ren;
  logic               wen;
  logic [WORD_W-1:0]  rd_data;
  logic [6:0]         shift_amt;
  logic [WORD_W-1:0]  lane_data;
  logic [ADDR_W:0]    step;
  result_t            result_next;

  // Bank access: display bank read, fill bank written
  assign pop   = (state == S_IDLE) && head.valid;
  assign raddr = {display_select, read_word_index};
  assign waddr = {~display_select, fill_word_index};
  assign ren   = pop && head.entry.op == OP_PIXEL;
  assign wen   = pop && head.entry.op == OP_BEAT && !fill_done && head.entry.store;

  ppplb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_bank_ram (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (head.entry.data),
    .re    (ren),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Lane select of the word read last cycle
  assign shift_amt = 7'(lane_index) * 7'(LANE_WIDTH);
  assign lane_data = rd_data >> shift_amt;
  assign step      = {1'b0, next_fetch_address} + STRIDE;

  // Item execution
  always_comb begin
    state_next              = state;
    read_word_index_next    = read_word_index;
    lane_index_next         = lane_index;
    fill_word_index_next    = fill_word_index;
    fill_done_next          = fill_done;
    display_select_next     = display_select;
    base_address_next       = base_address;
    top_address_next        = top_address;
    next_fetch_address_next = next_fetch_address;
    fetch_hold_next         = fetch_hold;
    pixel_hold_next         = pixel_hold;
    swapped_next            = 1'b0;
    emit                    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          unique case (head.entry.op)
            OP_PIXEL: begin
              state_next = S_READ;
            end
            OP_BEAT: begin
              emit = 1'b1;
              if (!fill_done) begin
                if (fill_word_index == WORD_LAST) begin
                  fill_word_index_next = '0;
                  fill_done_next       = 1'b1;
                end else begin
                  fill_word_index_next = fill_word_index + 1'b1;
                end
              end
            end
            OP_GRANT: begin
              emit            = 1'b1;
              fetch_hold_next = next_fetch_address;
              if (step < {1'b0, top_address}) begin
                next_fetch_address_next = step[ADDR_W-1:0];
              end else begin
                next_fetch_address_next = base_address;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        emit            = 1'b1;
        state_next      = S_IDLE;
        pixel_hold_next = rd_valid ? (lane_data[PIXEL_W-1:0] & PIX_MASK) : '0;
        if (lane_index == LANE_LAST) begin
          lane_index_next = '0;
          if (read_word_index == WORD_LAST) begin
            read_word_index_next = '0;
            display_select_next  = ~display_select;
            fill_word_index_next = '0;
            fill_done_next       = 1'b0;
            swapped_next         = 1'b1;
          end else begin
            read_word_index_next = read_word_index + 1'b1;
          end
        end else begin
          lane_index_next = lane_index + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Register writes, taken whenever valid; the sender is to send them only with nothing in flight, unenforced here
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_BASE: begin
          base_address_next       = cfg.data;
          next_fetch_address_next = cfg.data;
          fetch_hold_next         = cfg.data;
        end
        REG_TOP: begin
          top_address_next = cfg.data;
        end
        default: begin
        end
      endcase
    end

    result_next.pixel         = pixel_hold_next;
    result_next.fetch_address = fetch_hold_next;
    result_next.fetch_enable  = ~fill_done_next;
    result_next.display_bank  = display_select_next;
    result_next.swapped       = swapped_next;
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      read_word_index    <= '0;
      lane_index         <= '0;
      fill_word_index    <= '0;
      fill_done          <= 1'b0;
      display_select     <= 1'b0;
      base_address       <= '0;
      top_address        <= '0;
      next_fetch_address <= '0;
      fetch_hold         <= '0;
      pixel_hold         <= '0;
      word_valid         <= '0;
      result_valid       <= 1'b0;
    end else begin
      state              <= state_next;
      read_word_index    <= read_word_index_next;
      lane_index         <= lane_index_next;
      fill_word_index    <= fill_word_index_next;
      fill_done          <= fill_done_next;
      display_select     <= display_select_next;
      base_address       <= base_address_next;
      top_address        <= top_address_next;
      next_fetch_address <= next_fetch_address_next;
      fetch_hold         <= fetch_hold_next;
      pixel_hold         <= pixel_hold_next;
      result_valid       <= emit;
      if (wen) begin
        word_valid[waddr] <= 1'b1;
      end
    end
    if (ren) begin
      rd_valid <= word_valid[raddr];
    end
    result <= result_next;
  end

  `ASSERT_CLK(a_read_one_cycle, clk, rst, state == S_READ |=> state == S_IDLE, "read stuck")
  `ASSERT_CLK(a_fill_parked, clk, rst, fill_done |-> fill_word_index == '0, "fill index not parked")
  `ASSERT_CLK(a_swap_refill, clk, rst, result_valid && result.swapped |-> result.fetch_enable, "swap without refill")

endmodule

`default_nettype wire

// ----- design/pingpong_pixel_line_buffer.sv -----
// A beat, grant or unused item passes the front-end queue and the result register before
// its result strobe; a pixel request also waits in S_READ for the registered bank RAM read.
// One beat or grant per cycle while no pixel read is in S_READ; the back end takes no new
// item during a pixel read; busy rises when the two-entry queue is full.
// Reset (synchronous): indexes, bank select and registers clear; never-written words read 0.
`default_nettype none

module pingpong_pixel_line_buffer
  import ppplb_pkg::*;
#(
  parameter int WORDS_PER_BANK = 32,
  parameter int FETCH_STRIDE   = 256,
  parameter int PIXEL_BITS     = 12,
  parameter int LANES_PER_WORD = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire in_item_t               in_item,
  output logic                        result_valid,
  output result_t                     result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data
);

  queue_head_t head;
  logic        pop;
  cfg_write_t  cfg;

  // Register writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ppplb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .head    (head)
  );

  ppplb_back #(
    .WORDS_PER_BANK (WORDS_PER_BANK),
    .FETCH_STRIDE   (FETCH_STRIDE),
    .PIXEL_BITS     (PIXEL_BITS),
    .LANES_PER_WORD (LANES_PER_WORD)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
